>>> src/mavg_pkg.sv
package mavg_pkg;

  // converter code width, fixed by the sample format
  localparam int SMP_W        = 12;
  // defaults for the top-level parameters
  localparam int WINDOW_DEF   = 20;
  localparam int CHANNELS_DEF = 2;
  // depth of the request queue between front and back
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  // one classified request as it travels from front to back
  typedef struct packed {
    logic             bad;      // channel outside the configured range
    logic             channel;
    logic [SMP_W-1:0] sample;
  } item_t;

endpackage

>>> src/mavg_front.sv
module mavg_front
  import mavg_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  output logic             full_o,
  input  logic             channel_i,
  input  logic [SMP_W-1:0] sample_i,
  output item_t            q_item_o,
  output logic             q_empty_o,
  input  logic             q_pop_i
);

  item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push_ok;
  logic              pop_ok;
  item_t             item_in;

  assign full_o    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty_o = (cnt_r == '0);
  assign push_ok   = push_i && !full_o;
  assign pop_ok    = q_pop_i && !q_empty_o;
  assign q_item_o  = q_mem_r[rd_ptr_r];

  always_comb begin
    item_in.bad     = (32'(channel_i) >= CHANNELS);
    item_in.channel = channel_i;
    item_in.sample  = sample_i;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // back end must never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_i |-> (cnt_r != '0))
    else $error("request queue popped while empty");

endmodule

>>> src/mavg_div.sv
module mavg_div
  import mavg_pkg::*;
#(
  parameter int DVD_W = 17,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              qbit;

  // restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      // pulse on the cycle after the last quotient bit
      done_r <= !start_i && busy_r && (step_r == STEP_W'(DVD_W - 1));
      if (start_i) begin
        busy_r <= 1'b1;
        step_r <= '0;
        quo_r  <= dividend_i;
        rem_r  <= '0;
        dvs_r  <= divisor_i;
      end else if (busy_r) begin
        rem_r  <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_r  <= {quo_r[DVD_W-2:0], qbit};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done_o     = done_r;
  assign quotient_o = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r)
    else $error("divider started while busy");

endmodule

>>> src/mavg_back.sv
module mavg_back
  import mavg_pkg::*;
#(
  parameter int WINDOW   = WINDOW_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  item_t            q_item_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             res_valid_o,
  output logic [SMP_W-1:0] res_avg_o
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SMP_W + $clog2(WINDOW);
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RD,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t            state_r;
  item_t             item_r;
  logic [CH_W-1:0]   ch_r;
  logic [ADDR_W-1:0] idx_r;
  logic [SMP_W-1:0]  store_r [DEPTH];
  logic [SMP_W-1:0]  rd_data_r;
  logic [CNT_W-1:0]  fill_cnt_r [CHANNELS];
  logic [SLOT_W-1:0] slot_r [CHANNELS];
  logic [SUM_W-1:0]  sum_r [CHANNELS];
  logic              div_start_r;
  logic [SUM_W-1:0]  div_dvd_r;
  logic [CNT_W-1:0]  div_dvs_r;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic              res_valid_r;
  logic [SMP_W-1:0]  res_avg_r;

  logic              win_full;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [SLOT_W-1:0] slot_nxt;
  logic              res_free;
  logic              res_load;
  logic              mem_we;

  assign q_pop_o  = (state_r == ST_IDLE) && !q_empty_i;
  assign res_free = !res_valid_r || pop_i;
  assign res_load = (state_r == ST_OUT) && res_free;
  assign mem_we   = (state_r == ST_UPD);

  always_comb begin
    win_full = (fill_cnt_r[ch_r] == CNT_W'(WINDOW));
    sum_nxt  = sum_r[ch_r] - (win_full ? SUM_W'(rd_data_r) : '0) + SUM_W'(item_r.sample);
    cnt_nxt  = win_full ? fill_cnt_r[ch_r] : fill_cnt_r[ch_r] + 1'b1;
    slot_nxt = (slot_r[ch_r] == SLOT_W'(WINDOW - 1)) ? '0 : slot_r[ch_r] + 1'b1;
  end

  // sample store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[idx_r] <= item_r.sample;
    end
    rd_data_r <= store_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_start_r <= 1'b0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        fill_cnt_r[i] <= '0;
        slot_r[i]     <= '0;
        sum_r[i]      <= '0;
      end
    end else begin
      div_start_r <= (state_r == ST_UPD);
      // a new result may replace the one being taken in the same cycle
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (pop_i && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty_i) begin
            item_r  <= q_item_i;
            ch_r    <= q_item_i.bad ? '0 : CH_W'(q_item_i.channel);
            state_r <= q_item_i.bad ? ST_OUT : ST_LOOK;
          end
        end
        ST_LOOK: begin
          idx_r   <= ADDR_W'(int'(ch_r) * WINDOW + int'(slot_r[ch_r]));
          state_r <= ST_RD;
        end
        ST_RD: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          sum_r[ch_r]      <= sum_nxt;
          fill_cnt_r[ch_r] <= cnt_nxt;
          slot_r[ch_r]     <= slot_nxt;
          div_dvd_r        <= sum_nxt;
          div_dvs_r        <= cnt_nxt;
          state_r          <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (res_free) begin
            res_avg_r <= item_r.bad ? '0 : div_quo[SMP_W-1:0];
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  mavg_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start_r),
    .dividend_i (div_dvd_r),
    .divisor_i  (div_dvs_r),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign res_valid_o = res_valid_r;
  assign res_avg_o   = res_avg_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> (div_dvs_r != '0))
    else $error("divide started with zero count");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (fill_cnt_r[ch_r] <= CNT_W'(WINDOW)))
    else $error("fill count beyond window");

endmodule

>>> src/two_channel_moving_average.sv
// Path: a request passes the queue, store look-up and read, sum update, divider
//   and result register; a request on an unsupported channel skips to the result register.
// Requests: the back end takes a new request only once the last result is loaded;
//   its restoring divider yields one quotient bit per cycle.
// Reset: rst_n is synchronous, active low; clears fill counts, slots, sums,
//   queue and result flag. Sample store is not cleared: entries are only read once written.
module two_channel_moving_average
  import mavg_pkg::*;
#(
  parameter int WINDOW   = WINDOW_DEF,   // samples kept per channel, 2..32
  parameter int CHANNELS = CHANNELS_DEF  // channels with storage, 1..8
) (
  input  logic             clk,
  input  logic             rst_n,
  // request side
  input  logic             push,
  output logic             full,
  input  logic             in_channel,
  input  logic [SMP_W-1:0] in_sample,
  // result side
  output logic             empty,
  input  logic             pop,
  output logic [SMP_W-1:0] out_average
);

  // front: takes requests, flags an out-of-range channel, and queues them
  item_t q_item;
  logic  q_empty;
  logic  q_pop;
  logic  res_valid;

  mavg_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .full_o    (full),
    .channel_i (in_channel),
    .sample_i  (in_sample),
    .q_item_o  (q_item),
    .q_empty_o (q_empty),
    .q_pop_i   (q_pop)
  );

  // back: store read, running-sum update, divide by fill count, result register.
  // The result register lets the back end take and work on one more request while a result waits.
  mavg_back #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_item_i    (q_item),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_avg_o   (out_average)
  );

  assign empty = !res_valid;

endmodule
